FILE: sv/qwu_pkg.sv
// shared constants, register codes and a helper function for the quickprop weight update
// no dependencies; imported by the top level
package qwu_pkg;

    // register map codes (word index on the config port)
    localparam logic [2:0] REG_LEARN_RATE    = 3'd0;
    localparam logic [2:0] REG_MOMENTUM_GAIN = 3'd1;
    localparam logic [2:0] REG_MAX_GROWTH    = 3'd2;
    localparam logic [2:0] REG_MODE_THRESH   = 3'd3;
    localparam logic [2:0] REG_DIV_FAN_IN    = 3'd4;
    localparam logic [2:0] REG_DECAY_GAIN    = 3'd5;

    // reset values
    localparam logic [30:0] LEARN_RATE_RST    = 31'd36045;
    localparam logic [30:0] MOMENTUM_GAIN_RST = 31'd58982;
    localparam logic [30:0] MAX_GROWTH_RST    = 31'd114688;
    localparam logic [30:0] MODE_THRESH_RST   = 31'd0;
    localparam logic        DIV_FAN_IN_RST    = 1'b1;
    localparam logic [31:0] DECAY_GAIN_RST    = 32'hFFFF_FFF9;

    localparam int MAX_FAN_IN_DEF = 64;

    // quotient bits of every divider lane, also the number of divider stages
    localparam int DIV_W = 63;

    // magnitude cap of the quadratic term
    localparam logic [50:0] QUAD_LIMIT = 51'h4_0000_0000_0000;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: sv/qwu_div_pipe.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// no dependencies; the quotient is registered in the last stage and advances only on enabled edges
module qwu_div_pipe #(
    parameter int NW = 63,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    // numerator bits shift out the top while quotient bits fill the bottom
    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW-1:0] nq_prev;
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] den_prev;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          fits;
        logic [NW-1:0] nq_next;
        logic [DW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign nq_prev  = num;
            assign rem_prev = '0;
            assign den_prev = den;
        end
        else begin : g_rest
            assign nq_prev  = nq_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
        end

        // trial subtract of the divisor from the shifted remainder
        assign trial    = {rem_prev, nq_prev[NW-1]};
        assign diff     = trial - {1'b0, den_prev};
        assign fits     = (trial >= {1'b0, den_prev});
        assign nq_next  = {nq_prev[NW-2:0], fits};
        assign rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[k]  <= nq_next;
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_prev;
            end
        end
    end

    assign quo = nq_reg[NW-1];

endmodule

FILE: sv/qwu_delay.sv
// enabled delay line with valid bits, keeps side data aligned with the divider lanes
// no dependencies
module qwu_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_vld,
    input  logic [W-1:0] in_data,
    output logic         out_vld,
    output logic [W-1:0] out_data
);

    logic [DEPTH-1:0] vld_reg;
    logic [W-1:0]     data_reg [DEPTH];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_vld};
    end

    // data taps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++)
                data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_vld  = vld_reg[DEPTH-1];
    assign out_data = data_reg[DEPTH-1];

endmodule

FILE: sv/quickprop_weight_update_core.sv
// path: the 63-stage pipelined dividers (epsilon over fan-in, quadratic estimate, shrink factor)
// sit between stages c and d of the 8 stages a to h, which are followed by the output register
// throughput: one transaction per cycle; a stalled output parks one result in a skid register
// and input stalls while that register is occupied
// reset: rst_n clears all valid bits and loads the register defaults; no clearing pass
// depends on qwu_pkg, qwu_div_pipe, qwu_delay
module quickprop_weight_update_core
    import qwu_pkg::*;
#(
    parameter int MAX_FAN_IN = MAX_FAN_IN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] weight,
    input  logic signed [31:0] last_step,
    input  logic signed [31:0] slope,
    input  logic signed [31:0] previous_slope,
    input  logic [6:0]         fan_in,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_weight,
    output logic signed [31:0] new_step,
    output logic signed [31:0] slope_seed,
    output logic signed [31:0] slope_carry,
    output logic               used_gradient
);

    localparam int NFW = $clog2(MAX_FAN_IN + 1);
    localparam int FW  = (NFW > 7) ? NFW : 7;
    localparam int SBW = 4 * 32 + 4;

    // config registers
    logic [30:0]        learn_rate_reg;
    logic [30:0]        momentum_gain_reg;
    logic [30:0]        max_growth_reg;
    logic [30:0]        mode_thresh_reg;
    logic               div_fan_in_reg;
    logic signed [31:0] decay_gain_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg    <= LEARN_RATE_RST;
            momentum_gain_reg <= MOMENTUM_GAIN_RST;
            max_growth_reg    <= MAX_GROWTH_RST;
            mode_thresh_reg   <= MODE_THRESH_RST;
            div_fan_in_reg    <= DIV_FAN_IN_RST;
            decay_gain_reg    <= DECAY_GAIN_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_LEARN_RATE:    learn_rate_reg    <= pwdata[30:0];
                REG_MOMENTUM_GAIN: momentum_gain_reg <= pwdata[30:0];
                REG_MAX_GROWTH:    max_growth_reg    <= pwdata[30:0];
                REG_MODE_THRESH:   mode_thresh_reg   <= pwdata[30:0];
                REG_DIV_FAN_IN:    div_fan_in_reg    <= pwdata[0];
                REG_DECAY_GAIN:    decay_gain_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[4:2])
            REG_LEARN_RATE:    prdata = {1'b0, learn_rate_reg};
            REG_MOMENTUM_GAIN: prdata = {1'b0, momentum_gain_reg};
            REG_MAX_GROWTH:    prdata = {1'b0, max_growth_reg};
            REG_MODE_THRESH:   prdata = {1'b0, mode_thresh_reg};
            REG_DIV_FAN_IN:    prdata = {31'd0, div_fan_in_reg};
            REG_DECAY_GAIN:    prdata = decay_gain_reg;
            default:           prdata = '0;
        endcase
    end

    // global pipeline enable, held only while the skid register is occupied
    logic skid_v_reg;
    logic en;
    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;

    // stage a: input capture
    logic               a_v_reg;
    logic signed [31:0] a_w_reg, a_d_reg, a_s_reg, a_p_reg;
    logic [6:0]         a_fan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (en)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_w_reg   <= weight;
            a_d_reg   <= last_step;
            a_s_reg   <= slope;
            a_p_reg   <= previous_slope;
            a_fan_reg <= fan_in;
        end
    end

    // stage b: products, quadratic denominator, fan-in clamp
    logic               b_v_reg;
    logic signed [31:0] b_w_reg, b_d_reg, b_s_reg, b_p_reg;
    logic signed [63:0] b_eps_prod_reg, b_quad_prod_reg;
    logic signed [32:0] b_den_reg;
    logic [NFW-1:0]     b_n_reg;
    logic [FW-1:0]      fan_ext;
    logic [FW-1:0]      fan_clamp;

    always_comb
    begin
        fan_ext = FW'(a_fan_reg);
        if (fan_ext == '0)
            fan_clamp = FW'(1);
        else if (fan_ext > FW'(MAX_FAN_IN))
            fan_clamp = FW'(MAX_FAN_IN);
        else
            fan_clamp = fan_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (en)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_w_reg         <= a_w_reg;
            b_d_reg         <= a_d_reg;
            b_s_reg         <= a_s_reg;
            b_p_reg         <= a_p_reg;
            b_eps_prod_reg  <= $signed({1'b0, learn_rate_reg}) * a_s_reg;
            b_quad_prod_reg <= a_s_reg * a_d_reg;
            b_den_reg       <= {a_p_reg[31], a_p_reg} - {a_s_reg[31], a_s_reg};
            b_n_reg         <= fan_clamp[NFW-1:0];
        end
    end

    // stage c: magnitudes and signs for the dividers
    logic               c_v_reg;
    logic signed [31:0] c_w_reg, c_d_reg, c_s_reg, c_p_reg;
    logic [DIV_W-1:0]   c_eps_mag_reg, c_num_mag_reg;
    logic [32:0]        c_den_mag_reg;
    logic               c_eps_neg_reg, c_quad_neg_reg, c_den_zero_reg, c_num_zero_reg;
    logic [NFW-1:0]     c_n_reg;
    logic [63:0]        eps_abs, num_abs;
    logic [32:0]        den_abs;

    assign eps_abs = b_eps_prod_reg[63] ? 64'(-b_eps_prod_reg) : 64'(b_eps_prod_reg);
    assign num_abs = b_quad_prod_reg[63] ? 64'(-b_quad_prod_reg) : 64'(b_quad_prod_reg);
    assign den_abs = b_den_reg[32] ? 33'(-b_den_reg) : 33'(b_den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (en)
            c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_w_reg        <= b_w_reg;
            c_d_reg        <= b_d_reg;
            c_s_reg        <= b_s_reg;
            c_p_reg        <= b_p_reg;
            c_eps_mag_reg  <= eps_abs[DIV_W-1:0];
            c_num_mag_reg  <= num_abs[DIV_W-1:0];
            c_den_mag_reg  <= den_abs;
            c_eps_neg_reg  <= b_eps_prod_reg[63];
            c_quad_neg_reg <= b_quad_prod_reg[63] ^ b_den_reg[32];
            c_den_zero_reg <= (b_den_reg == '0);
            c_num_zero_reg <= (b_quad_prod_reg == '0);
            c_n_reg        <= div_fan_in_reg ? b_n_reg : NFW'(1);
        end
    end

    // divider lanes
    logic [DIV_W-1:0] eps_q, quad_q, shrink_q;
    logic [DIV_W-1:0] shrink_num;
    logic [31:0]      shrink_den;

    assign shrink_num = DIV_W'({max_growth_reg, 16'd0});
    assign shrink_den = {1'b0, max_growth_reg} + 32'd65536;

    qwu_div_pipe #(.NW(DIV_W), .DW(NFW)) u_div_eps (
        .clk (clk),
        .en  (en),
        .num (c_eps_mag_reg),
        .den (c_n_reg),
        .quo (eps_q)
    );

    qwu_div_pipe #(.NW(DIV_W), .DW(33)) u_div_quad (
        .clk (clk),
        .en  (en),
        .num (c_num_mag_reg),
        .den (c_den_mag_reg),
        .quo (quad_q)
    );

    qwu_div_pipe #(.NW(DIV_W), .DW(32)) u_div_shrink (
        .clk (clk),
        .en  (en),
        .num (shrink_num),
        .den (shrink_den),
        .quo (shrink_q)
    );

    // side data alongside the dividers
    logic           dl_v;
    logic [SBW-1:0] dl_data;
    logic signed [31:0] dl_w, dl_d, dl_s, dl_p;
    logic           dl_eps_neg, dl_quad_neg, dl_den_zero, dl_num_zero;

    qwu_delay #(.W(SBW), .DEPTH(DIV_W)) u_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c_v_reg),
        .in_data  ({c_w_reg, c_d_reg, c_s_reg, c_p_reg, c_eps_neg_reg, c_quad_neg_reg,
                    c_den_zero_reg, c_num_zero_reg}),
        .out_vld  (dl_v),
        .out_data (dl_data)
    );

    assign {dl_w, dl_d, dl_s, dl_p, dl_eps_neg, dl_quad_neg, dl_den_zero, dl_num_zero} = dl_data;

    // stage d: signed terms and second-round products
    logic               d_v_reg;
    logic signed [31:0] d_w_reg, d_d_reg, d_s_reg;
    logic signed [47:0] d_eps_reg;
    logic signed [51:0] d_quad_reg;
    logic signed [48:0] d_lim_prod_reg;
    logic signed [63:0] d_jump_prod_reg, d_mom_prod_reg;
    logic signed [63:0] eps_sgn, eps_shr;
    logic [50:0]        quad_mag;
    logic signed [51:0] quad_sgn;

    assign eps_sgn = dl_eps_neg ? -$signed({1'b0, eps_q}) : $signed({1'b0, eps_q});
    assign eps_shr = eps_sgn >>> 16;

    // quadratic term, capped; a zero denominator saturates in the numerator's sign
    always_comb
    begin
        if (dl_den_zero)
            quad_mag = dl_num_zero ? '0 : QUAD_LIMIT;
        else if (quad_q > DIV_W'(QUAD_LIMIT))
            quad_mag = QUAD_LIMIT;
        else
            quad_mag = quad_q[50:0];
        quad_sgn = dl_quad_neg ? -$signed({1'b0, quad_mag}) : $signed({1'b0, quad_mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (en)
            d_v_reg <= dl_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_w_reg         <= dl_w;
            d_d_reg         <= dl_d;
            d_s_reg         <= dl_s;
            d_eps_reg       <= eps_shr[47:0];
            d_quad_reg      <= quad_sgn;
            d_lim_prod_reg  <= $signed({1'b0, shrink_q[15:0]}) * dl_p;
            d_jump_prod_reg <= $signed({1'b0, max_growth_reg}) * dl_d;
            d_mom_prod_reg  <= $signed({1'b0, momentum_gain_reg}) * dl_d;
        end
    end

    // stage e: mode selection and step sum
    logic               e_v_reg;
    logic signed [31:0] e_w_reg, e_s_reg, e_step_reg;
    logic               e_grad_reg;
    logic signed [48:0] lim_shr;
    logic signed [32:0] limit, d33, s33, thr33;
    logic signed [63:0] jump_t, mom_t;
    logic signed [55:0] step_sum;
    logic               pos, negm, grad, eps_add, jump;

    always_comb
    begin
        lim_shr  = d_lim_prod_reg >>> 16;
        limit    = lim_shr[32:0];
        jump_t   = d_jump_prod_reg >>> 16;
        mom_t    = d_mom_prod_reg >>> 16;
        d33      = 33'(d_d_reg);
        s33      = 33'(d_s_reg);
        thr33    = $signed({2'b00, mode_thresh_reg});
        pos      = d33 > thr33;
        negm     = d33 < -thr33;
        grad     = !(pos || negm);
        eps_add  = pos ? (d_s_reg > 32'sd0) : (d_s_reg < 32'sd0);
        jump     = pos ? (s33 > limit) : (s33 < limit);
        if (grad)
            step_sum = 56'(d_eps_reg) + 56'(mom_t);
        else
            step_sum = (eps_add ? 56'(d_eps_reg) : 56'sd0)
                       + (jump ? 56'(jump_t) : 56'(d_quad_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else if (en)
            e_v_reg <= d_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_w_reg    <= d_w_reg;
            e_s_reg    <= d_s_reg;
            e_step_reg <= sat32(64'(step_sum));
            e_grad_reg <= grad;
        end
    end

    // stage f: new weight
    logic               f_v_reg;
    logic signed [31:0] f_nw_reg, f_step_reg, f_s_reg;
    logic               f_grad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (en)
            f_v_reg <= e_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_nw_reg   <= sat32(64'(e_w_reg) + 64'(e_step_reg));
            f_step_reg <= e_step_reg;
            f_s_reg    <= e_s_reg;
            f_grad_reg <= e_grad_reg;
        end
    end

    // stage g: decay product
    logic               g_v_reg;
    logic signed [31:0] g_nw_reg, g_step_reg, g_s_reg;
    logic signed [63:0] g_seed_prod_reg;
    logic               g_grad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_v_reg <= 1'b0;
        else if (en)
            g_v_reg <= f_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_nw_reg        <= f_nw_reg;
            g_step_reg      <= f_step_reg;
            g_s_reg         <= f_s_reg;
            g_grad_reg      <= f_grad_reg;
            g_seed_prod_reg <= decay_gain_reg * f_nw_reg;
        end
    end

    // stage h: seed saturation, last pipeline stage
    typedef struct packed {
        logic signed [31:0] nw;
        logic signed [31:0] step;
        logic signed [31:0] seed;
        logic signed [31:0] carry;
        logic               grad;
    } result_t;

    logic               h_v_reg;
    result_t            h_res_reg;
    logic signed [63:0] seed_shr;

    assign seed_shr = g_seed_prod_reg >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_v_reg <= 1'b0;
        else if (en)
            h_v_reg <= g_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_res_reg.nw    <= g_nw_reg;
            h_res_reg.step  <= g_step_reg;
            h_res_reg.seed  <= sat32(seed_shr);
            h_res_reg.carry <= g_s_reg;
            h_res_reg.grad  <= g_grad_reg;
        end
    end

    // output register and skid register
    logic    out_v_reg;
    result_t out_res_reg;
    result_t skid_res_reg;
    logic    out_free;

    assign out_free = !out_v_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_free)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (out_free)
            out_v_reg <= h_v_reg;
        else if (h_v_reg)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_free)
                out_res_reg <= skid_res_reg;
        end
        else if (out_free)
            out_res_reg <= h_res_reg;
        else
            skid_res_reg <= h_res_reg;
    end

    assign out_valid     = out_v_reg;
    assign new_weight    = out_res_reg.nw;
    assign new_step      = out_res_reg.step;
    assign slope_seed    = out_res_reg.seed;
    assign slope_carry   = out_res_reg.carry;
    assign used_gradient = out_res_reg.grad;

    // the skid register only holds a transaction behind an occupied output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register full while output register empty");

    // a full skid register drains as soon as the output frees up
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && !out_stall) |=> !skid_v_reg)
        else $error("skid register did not drain");

    // a finished transaction blocked at the output moves into the skid register
    a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (!skid_v_reg && h_v_reg && out_v_reg && out_stall) |=> skid_v_reg)
        else $error("finished transaction lost behind a stalled output");

    // pipeline freezes while the skid register is occupied
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && out_stall) |=> $stable(h_v_reg))
        else $error("pipeline advanced while frozen");

endmodule

FILE: test/quickprop_weight_update_core_test.sv
// self-checking regression for quickprop_weight_update_core: directed table, then random traffic
// depends on qwu_pkg and the core RTL; results are checked against a local fixed-point predictor
`timescale 1ns / 1ps

module quickprop_weight_update_core_test
    import qwu_pkg::*;
();

    localparam logic [2:0] REG_UNUSED_A = 3'd6;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;
    localparam longint     QUAD_CAP     = longint'(1) << 50;
    localparam int         FAN_CAP      = 64;
    localparam int         DRAIN_CYCLES = 120;

    typedef struct {
        logic signed [31:0] weight;
        logic signed [31:0] last_step;
        logic signed [31:0] slope;
        logic signed [31:0] previous_slope;
        logic [6:0]         fan_in;
    } conn_t;

    typedef struct {
        logic signed [31:0] new_weight;
        logic signed [31:0] new_step;
        logic signed [31:0] slope_seed;
        logic signed [31:0] slope_carry;
        logic               used_gradient;
    } update_t;

    typedef struct {
        conn_t   conn;
        bit      typed;
        update_t upd;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] weight = '0, last_step = '0, slope = '0, previous_slope = '0;
    logic [6:0] fan_in = 7'd1;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] new_weight, new_step, slope_seed, slope_carry;
    logic used_gradient;

    // local copy of the register file
    logic [30:0] lr_q = LEARN_RATE_RST;
    logic [30:0] mom_q = MOMENTUM_GAIN_RST;
    logic [30:0] mu_q = MAX_GROWTH_RST;
    logic [30:0] thr_q = MODE_THRESH_RST;
    logic        div_q = DIV_FAN_IN_RST;
    logic [31:0] decay_q = DECAY_GAIN_RST;

    update_t expected_updates[$];
    row_t    directed_rows[$];
    int      fail_count = 0;
    int      sent_count = 0, grad_count = 0;

    quickprop_weight_update_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .weight(weight), .last_step(last_step), .slope(slope),
        .previous_slope(previous_slope), .fan_in(fan_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_weight(new_weight), .new_step(new_step), .slope_seed(slope_seed),
        .slope_carry(slope_carry), .used_gradient(used_gradient)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("quickprop_weight_update_core regression: fail");
        $finish;
    end

    function automatic logic signed [31:0] clip32(input longint v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // fixed-point quickprop update under the current register copy
    function automatic update_t predict_update(input conn_t c);
        update_t u;
        longint w, d, s, p, n, thr, mu, lr, mom, decay;
        longint eps_prod, eps_term, shrink, lim, step, den, num, q, nw;
        bit pos;
        w = c.weight; d = c.last_step; s = c.slope; p = c.previous_slope;
        n = c.fan_in; thr = thr_q; mu = mu_q; lr = lr_q; mom = mom_q;
        decay = $signed(decay_q);
        u.used_gradient = 1'b0;
        if (n == 0)
            n = 1;
        if (n > FAN_CAP)
            n = FAN_CAP;
        eps_prod = lr * s;
        if (div_q)
            eps_prod = eps_prod / n;
        eps_term = eps_prod >>> 16;
        shrink = (mu << 16) / (mu + 65536);
        lim = (shrink * p) >>> 16;
        if (d > thr || d < -thr)
        begin
            pos = d > thr;
            step = 0;
            if (pos ? (s > 0) : (s < 0))
                step += eps_term;
            if (pos ? (s > lim) : (s < lim))
                step += (mu * d) >>> 16;
            else
            begin
                den = p - s;
                num = s * d;
                if (den == 0)
                    q = (num > 0) ? QUAD_CAP : ((num < 0) ? -QUAD_CAP : 0);
                else
                begin
                    q = num / den;
                    if (q > QUAD_CAP) q = QUAD_CAP;
                    if (q < -QUAD_CAP) q = -QUAD_CAP;
                end
                step += q;
            end
        end
        else
        begin
            u.used_gradient = 1'b1;
            step = eps_term + ((mom * d) >>> 16);
        end
        u.new_step = clip32(step);
        nw = longint'(w) + longint'(u.new_step);
        u.new_weight = clip32(nw);
        u.slope_seed = clip32((decay * longint'(u.new_weight)) >>> 16);
        u.slope_carry = c.slope;
        return u;
    endfunction

    // register write: setup then access phase
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            REG_LEARN_RATE:    lr_q = value[30:0];
            REG_MOMENTUM_GAIN: mom_q = value[30:0];
            REG_MAX_GROWTH:    mu_q = value[30:0];
            REG_MODE_THRESH:   thr_q = value[30:0];
            REG_DIV_FAN_IN:    div_q = value[0];
            REG_DECAY_GAIN:    decay_q = value;
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // drive one transaction and queue its expected update once accepted
    task automatic send_conn(input conn_t c, input bit typed, input update_t typed_upd);
        update_t u;
        @(negedge clk);
        in_valid = 1'b1;
        weight = c.weight; last_step = c.last_step; slope = c.slope;
        previous_slope = c.previous_slope; fan_in = c.fan_in;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        u = typed ? typed_upd : predict_update(c);
        expected_updates.push_back(u);
        sent_count++;
        if (u.used_gradient)
            grad_count++;
    endtask

    task automatic idle_for(input int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // hold the sender until every result is back, then let the pipe empty
    task automatic drain_all();
        idle_for(1);
        while (expected_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_q16(input int shape);
        logic signed [31:0] v;
        case (shape)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            2: v = $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
            default: v = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
        return v;
    endfunction

    // mostly plausible training data, some raw noise and corner values
    function automatic conn_t rand_conn();
        conn_t c;
        int shape;
        shape = $urandom_range(0, 9);
        shape = (shape < 2) ? 0 : ((shape < 8) ? $urandom_range(1, 2) : (shape == 8 ? 0 : 3));
        c.weight = rand_q16($urandom_range(0, 3) == 0 ? 0 : 1);
        c.last_step = rand_q16(shape);
        if ($urandom_range(0, 5) == 0)
            c.last_step = $signed({1'b0, thr_q}) + $signed($urandom_range(0, 4)) - 2;
        c.slope = rand_q16(shape == 3 ? $urandom_range(0, 3) : shape);
        case ($urandom_range(0, 5))
            0: c.previous_slope = c.slope;
            1: c.previous_slope = c.slope + $signed($urandom_range(0, 64)) - 32;
            default: c.previous_slope = rand_q16(shape == 3 ? $urandom_range(0, 3) : shape);
        endcase
        c.fan_in = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(1, 64));
        return c;
    endfunction

    task automatic add_row(input logic signed [31:0] w, d, s, p, input logic [6:0] n);
        row_t r;
        r.conn = '{w, d, s, p, n};
        r.typed = 1'b0;
        r.upd = '{0, 0, 0, 0, 1'b0};
        directed_rows.push_back(r);
    endtask

    task automatic add_typed(input logic signed [31:0] w, input logic signed [31:0] seed);
        row_t r;
        r.conn = '{w, 0, 0, 0, 7'd1};
        r.typed = 1'b1;
        r.upd = '{w, 0, seed, 0, 1'b1};
        directed_rows.push_back(r);
    endtask

    // result checker
    always @(posedge clk)
    begin
        update_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_updates.size() == 0)
            begin
                $error("unexpected result transaction, new_weight %0d", new_weight);
                fail_count++;
            end
            else
            begin
                e = expected_updates.pop_front();
                if (new_weight !== e.new_weight)
                begin
                    $error("new_weight exp %0d got %0d", e.new_weight, new_weight);
                    fail_count++;
                end
                if (new_step !== e.new_step)
                begin
                    $error("new_step exp %0d got %0d", e.new_step, new_step);
                    fail_count++;
                end
                if (slope_seed !== e.slope_seed)
                begin
                    $error("slope_seed exp %0d got %0d", e.slope_seed, slope_seed);
                    fail_count++;
                end
                if (slope_carry !== e.slope_carry)
                begin
                    $error("slope_carry exp %0d got %0d", e.slope_carry, slope_carry);
                    fail_count++;
                end
                if (used_gradient !== e.used_gradient)
                begin
                    $error("used_gradient exp %0d got %0d", e.used_gradient, used_gradient);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure in one of four randomly chosen styles
    always @(negedge clk)
    begin
        int cyc;
        int stall_mode;
        cyc++;
        if (cyc % 200 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (cyc % 7) < 3;
        endcase
    end

    // stimulus
    initial
    begin
        conn_t c;
        update_t none;
        int burst_left;
        none = '{0, 0, 0, 0, 1'b0};
        burst_left = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table under reset defaults
        add_typed(32'sh0, 32'sh0);
        add_typed(32'sh7FFF_FFFF, -32'sd229376);
        add_typed(32'sh8000_0000, 32'sd229376);
        add_row(0, 0, 32'sh7FFF_FFFF, 0, 7'd1);
        add_row(0, 0, 32'sh8000_0000, 0, 7'd0);
        add_row(0, 0, 32'sh8000_0000, 0, 7'd127);
        add_row(0, 0, 32'sh8000_0000, 0, 7'd64);
        add_row(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0000_4000, 7'd4);
        add_row(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_1000, 32'sh0000_4000, 7'd4);
        add_row(-32'sh0001_0000, -32'sh0001_0000, -32'sd1000, -32'sd100, 7'd8);
        add_row(-32'sh0001_0000, -32'sh0001_0000, -32'sd10, -32'sd100000, 7'd8);
        add_row(32'sh0000_1234, 32'sh0001_0000, -32'sd100, -32'sd100, 7'd2);
        add_row(32'sh0000_1234, -32'sh0001_0000, 32'sd100, 32'sd100, 7'd2);
        add_row(32'sh0000_1234, 32'sh0001_0000, 0, 0, 7'd2);
        add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7'd1);
        add_row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 7'd1);
        add_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 7'd33);
        add_row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 7'd1);
        add_row(32'sh0055_AA00, 32'sh7FFF_FFFF, 32'sd1, 32'sh8000_0000, 7'd94);
        foreach (directed_rows[i])
            send_conn(directed_rows[i].conn, directed_rows[i].typed, directed_rows[i].upd);
        drain_all();

        // register settings per phase, extremes first, then random ones
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_LEARN_RATE, 32'h7FFF_FFFF);
                    write_reg(REG_MOMENTUM_GAIN, 32'h7FFF_FFFF);
                    write_reg(REG_MAX_GROWTH, 32'h7FFF_FFFF);
                    write_reg(REG_MODE_THRESH, 32'h0000_0800);
                    write_reg(REG_DIV_FAN_IN, 32'h0);
                    write_reg(REG_DECAY_GAIN, 32'h7FFF_FFFF);
                end
                1:
                begin
                    write_reg(REG_LEARN_RATE, 32'h0);
                    write_reg(REG_MOMENTUM_GAIN, 32'h0);
                    write_reg(REG_MAX_GROWTH, 32'h0);
                    write_reg(REG_MODE_THRESH, 32'h7FFF_FFFF);
                    write_reg(REG_DIV_FAN_IN, 32'hFFFF_FFFF);
                    write_reg(REG_DECAY_GAIN, 32'h8000_0000);
                end
                2:
                begin
                    write_reg(REG_MODE_THRESH, 32'h0);
                    write_reg(REG_MAX_GROWTH, 32'hFFFF_FFFF);
                    write_reg(REG_LEARN_RATE, 32'hFFFF_FFFF);
                    write_reg(REG_UNUSED_A, 32'hDEAD_BEEF);
                    write_reg(REG_UNUSED_B, 32'h1234_5678);
                end
                default:
                begin
                    write_reg(REG_LEARN_RATE, $urandom_range(0, 32'h0004_0000));
                    write_reg(REG_MOMENTUM_GAIN, $urandom_range(0, 32'h0002_0000));
                    write_reg(REG_MAX_GROWTH, $urandom_range(0, 32'h0006_0000));
                    write_reg(REG_MODE_THRESH, ($urandom_range(0, 2) == 0) ? 0
                                               : $urandom_range(0, 32'h0000_4000));
                    write_reg(REG_DIV_FAN_IN, $urandom);
                    write_reg(REG_DECAY_GAIN, ($urandom_range(0, 3) == 0) ? $urandom
                                              : $urandom_range(0, 64) - 32);
                end
            endcase

            // bursty random traffic
            for (int k = 0; k < 95; k++)
            begin
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 2) != 0)
                        idle_for($urandom_range(1, 9));
                    burst_left = $urandom_range(1, 40);
                end
                burst_left--;
                c = rand_conn();
                send_conn(c, 1'b0, none);
            end
            drain_all();
        end

        $display("covered %0d weight updates, %0d in gradient mode, across 10 register settings",
                 sent_count, grad_count);
        $display("register extremes, fan-in clamping, zero quadratic denominators and stalls hit");
        if (fail_count == 0)
            $display("quickprop_weight_update_core regression: pass");
        else
            $display("quickprop_weight_update_core regression: fail");
        $finish;
    end

endmodule
